// ===== rtl/efr_pkg.sv =====
// ----------------------------------------------------------------------------
// efr_pkg
// Shared types, constants and the CRC-32 byte fold for the escaped frame
// receiver.
// ----------------------------------------------------------------------------
package efr_pkg;

  // Framing bytes
  localparam logic [7:0] EndByte    = 8'hFF;
  localparam logic [7:0] EscByte    = 8'hFE;
  localparam logic [7:0] EscCodeFf  = 8'hFD;
  localparam logic [7:0] EscCodeFe  = 8'hFC;

  // Header is size word then CRC word, 4 bytes each
  localparam int unsigned HdrBytes   = 8;
  localparam int unsigned HdrCntW    = 4;

  // CRC-32, reflected
  localparam logic [31:0] CrcPoly    = 32'hEDB88320;
  localparam logic [31:0] CrcAllOnes = 32'hFFFFFFFF;

  // Default payload limit and queue depth
  localparam int unsigned MaxPayloadDflt = 256;
  localparam int unsigned QueueDepth     = 2;

  // Result kinds
  localparam logic KindData   = 1'b0;
  localparam logic KindStatus = 1'b1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SIZE = 2'd1,
    ST_CRC  = 2'd2,
    ST_OVF  = 2'd3
  } status_e;

  // Classified request handed from front to back
  typedef struct packed {
    logic       is_end;
    logic [7:0] data;
  } efr_op_t;

  // One byte into the reflected CRC register, bit at a time
  function automatic logic [31:0] crc_fold(input logic [31:0] crc_in,
                                           input logic [7:0]  data);
    logic [31:0] crc;
    crc = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CrcPoly;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

// ===== rtl/efr_rx_if.sv =====
// ----------------------------------------------------------------------------
// efr_rx_if
// Raw byte channel from the serial link.
// ----------------------------------------------------------------------------
interface efr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/efr_res_if.sv =====
// ----------------------------------------------------------------------------
// efr_res_if
// Result channel: payload bytes and end-of-frame status items.
// ----------------------------------------------------------------------------
interface efr_res_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] payload_byte;
  logic [1:0] frame_status;
  logic [8:0] payload_length;
  logic       last;

  modport source (output valid, output kind, output payload_byte,
                  output frame_status, output payload_length, output last,
                  input ready);
  modport sink   (input valid, input kind, input payload_byte,
                  input frame_status, input payload_length, input last,
                  output ready);
endinterface

// ===== rtl/efr_queue.sv =====
// ----------------------------------------------------------------------------
// efr_queue
// Short FIFO of classified requests between the front and back parts.
// ----------------------------------------------------------------------------
module efr_queue
  import efr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  efr_op_t push_op_i,
  output logic    full_o,
  input  logic    pop_i,
  output efr_op_t head_op_o,
  output logic    empty_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  efr_op_t         mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o    = (cnt_q == CntW'(QueueDepth));
  assign empty_o   = (cnt_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign head_op_o = mem_q[rd_ptr_q];

  // Pointer and fill-count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

// ===== rtl/efr_front.sv =====
// ----------------------------------------------------------------------------
// efr_front
// Accepts raw bytes, drops the start byte, resolves escapes and passes
// unescaped bytes and frame ends on as requests.
// ----------------------------------------------------------------------------
module efr_front
  import efr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  efr_rx_if.sink    rx_i,
  output logic      op_valid_o,
  output efr_op_t   op_o,
  input  logic      op_full_i
);

  logic start_seen_q, start_seen_d;
  logic esc_pend_q, esc_pend_d;
  logic accept;

  assign rx_i.ready = !op_full_i;
  assign accept     = rx_i.valid && rx_i.ready;

  // Byte classification
  always_comb begin
    start_seen_d = start_seen_q;
    esc_pend_d   = esc_pend_q;
    op_valid_o   = 1'b0;
    op_o.is_end  = 1'b0;
    op_o.data    = rx_i.rx_byte;
    if (accept) begin
      priority if (rx_i.rx_byte == EndByte) begin
        // raw end byte always closes, pending escape is dropped
        op_valid_o   = 1'b1;
        op_o.is_end  = 1'b1;
        start_seen_d = 1'b0;
        esc_pend_d   = 1'b0;
      end else if (!start_seen_q) begin
        start_seen_d = 1'b1;
      end else if (esc_pend_q) begin
        esc_pend_d = 1'b0;
        op_valid_o = 1'b1;
        priority if (rx_i.rx_byte == EscCodeFf) begin
          op_o.data = EndByte;
        end else if (rx_i.rx_byte == EscCodeFe) begin
          op_o.data = EscByte;
        end else begin
          op_o.data = 8'h00;
        end
      end else if (rx_i.rx_byte == EscByte) begin
        esc_pend_d = 1'b1;
      end else begin
        op_valid_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_seen_q <= 1'b0;
      esc_pend_q   <= 1'b0;
    end else begin
      start_seen_q <= start_seen_d;
      esc_pend_q   <= esc_pend_d;
    end
  end

endmodule

// ===== rtl/efr_back.sv =====
// ----------------------------------------------------------------------------
// efr_back
// Assembles the header, folds payload bytes into the CRC, counts the payload
// and drives the registered result stage.
// ----------------------------------------------------------------------------
module efr_back
  import efr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MaxPayloadDflt
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      op_empty_i,
  input  efr_op_t   op_i,
  output logic      op_pop_o,
  efr_res_if.source res_o
);

  localparam int unsigned PcntW = $clog2(MAX_PAYLOAD + 1);

  logic [HdrCntW-1:0] hdr_cnt_q, hdr_cnt_d;
  logic [PcntW-1:0]   pcnt_q, pcnt_d;
  logic [31:0]        size_q, size_d;
  logic [31:0]        crc_field_q, crc_field_d;
  logic [31:0]        crc_q, crc_d;
  logic               ovf_q, ovf_d;

  logic               out_valid_q, out_valid_d;
  logic               kind_q, kind_d;
  logic [7:0]         byte_q, byte_d;
  status_e            status_q, status_d;
  logic [8:0]         len_q, len_d;

  logic               slot_free;
  logic               header_ok;
  logic [31:0]        plen32;

  assign slot_free = !out_valid_q || res_o.ready;
  assign op_pop_o  = !op_empty_i && slot_free;
  assign header_ok = (hdr_cnt_q == HdrCntW'(HdrBytes));
  assign plen32    = 32'(pcnt_q);

  // Frame bookkeeping and result forming
  always_comb begin
    hdr_cnt_d   = hdr_cnt_q;
    pcnt_d      = pcnt_q;
    size_d      = size_q;
    crc_field_d = crc_field_q;
    crc_d       = crc_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !res_o.ready;
    kind_d      = kind_q;
    byte_d      = byte_q;
    status_d    = status_q;
    len_d       = len_q;
    if (op_pop_o) begin
      if (op_i.is_end) begin
        out_valid_d = 1'b1;
        kind_d      = KindStatus;
        byte_d      = 8'h00;
        len_d       = plen32[8:0];
        priority if (ovf_q) begin
          status_d = ST_OVF;
        end else if (!header_ok || size_q != plen32) begin
          status_d = ST_SIZE;
        end else if ((crc_q ^ CrcAllOnes) != crc_field_q) begin
          status_d = ST_CRC;
        end else begin
          status_d = ST_OK;
        end
        hdr_cnt_d   = '0;
        pcnt_d      = '0;
        size_d      = '0;
        crc_field_d = '0;
        crc_d       = CrcAllOnes;
        ovf_d       = 1'b0;
      end else if (!hdr_cnt_q[2] && !header_ok) begin
        // size word, little-endian
        size_d[8*hdr_cnt_q[1:0] +: 8] = op_i.data;
        hdr_cnt_d = hdr_cnt_q + 1'b1;
      end else if (!header_ok) begin
        // CRC word, little-endian
        crc_field_d[8*hdr_cnt_q[1:0] +: 8] = op_i.data;
        hdr_cnt_d = hdr_cnt_q + 1'b1;
      end else if (pcnt_q == PcntW'(MAX_PAYLOAD)) begin
        ovf_d = 1'b1;
      end else begin
        pcnt_d      = pcnt_q + 1'b1;
        crc_d       = crc_fold(crc_q, op_i.data);
        out_valid_d = 1'b1;
        kind_d      = KindData;
        byte_d      = op_i.data;
        status_d    = ST_OK;
        len_d       = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_cnt_q   <= '0;
      pcnt_q      <= '0;
      size_q      <= '0;
      crc_field_q <= '0;
      crc_q       <= CrcAllOnes;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      hdr_cnt_q   <= hdr_cnt_d;
      pcnt_q      <= pcnt_d;
      size_q      <= size_d;
      crc_field_q <= crc_field_d;
      crc_q       <= crc_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    byte_q   <= byte_d;
    status_q <= status_d;
    len_q    <= len_d;
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.kind           = kind_q;
  assign res_o.payload_byte   = byte_q;
  assign res_o.frame_status   = status_q;
  assign res_o.payload_length = len_q;
  assign res_o.last           = kind_q;

  // Payload count stays zero until the header is complete
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !header_ok |-> pcnt_q == '0)
    else $error("payload counted before header complete");

  // A frame end leaves all frame state cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_pop_o && op_i.is_end |=> hdr_cnt_q == '0 && !ovf_q && crc_q == CrcAllOnes)
    else $error("frame state not cleared after end");

  // Overflow can only be flagged with a full payload count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> pcnt_q == PcntW'(MAX_PAYLOAD))
    else $error("overflow without full payload");

  // Nothing is popped while a result is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_o.ready |-> !op_pop_o)
    else $error("request popped into a stalled result slot");

endmodule

// ===== rtl/escaped_frame_receiver_crc32.sv =====
// ----------------------------------------------------------------------------
// escaped_frame_receiver_crc32
// Byte-stuffed frame receiver: unescapes, strips the size/CRC header, passes
// payload bytes out and closes each frame with a CRC-32 checked status item.
//
//   channel | dir | payload                                           | role
//   rx_i    | in  | rx_byte[7:0]                                      | raw link bytes
//   res_o   | out | kind, payload_byte, frame_status, payload_length, | data / status
//           |     | last                                              |
//
// One byte per cycle sustained while res_o does not stall; each request is
// written into the queue, then popped into the registered result stage that
// drives res_o. The rate rests on the back part's combinational CRC fold.
// Reset (rst_ni low, asynchronous) clears the frame state and empties the queue.
// A stall on res_o fills the two-entry queue, then drops rx_i.ready.
// ----------------------------------------------------------------------------
module escaped_frame_receiver_crc32
  import efr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MaxPayloadDflt
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  efr_rx_if.sink    rx_i,
  efr_res_if.source res_o
);

  logic    push;
  efr_op_t push_op;
  logic    full;
  logic    pop;
  efr_op_t head_op;
  logic    empty;

  efr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_i       (rx_i),
    .op_valid_o (push),
    .op_o       (push_op),
    .op_full_i  (full)
  );

  efr_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .full_o    (full),
    .pop_i     (pop),
    .head_op_o (head_op),
    .empty_o   (empty)
  );

  efr_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_empty_i (empty),
    .op_i       (head_op),
    .op_pop_o   (pop),
    .res_o      (res_o)
  );

endmodule

// ===== dv/efr_frame_checker.sv =====
// ----------------------------------------------------------------------------
// efr_frame_checker
// Watches both channels of the escaped frame receiver. Every accepted raw
// byte runs through a local deframer that mirrors the frame state and yields
// the payload byte or end-of-frame status it should cause. Accepted results
// are compared in order against those, and failures are counted.
// ----------------------------------------------------------------------------
module efr_frame_checker
  import efr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MaxPayloadDflt
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  efr_rx_if           rx_mon,
  efr_res_if          res_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_count_o
);

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    status_e    frame_status;
    logic [8:0] payload_length;
    logic       last;
  } frame_res_t;

  // Mirrored frame state
  logic        start_seen;
  logic        esc_pending;
  logic        ovf_seen;
  logic [8:0]  unesc_cnt;
  logic [31:0] size_word;
  logic [31:0] crc_word;
  logic [31:0] crc_acc;

  // Results still owed by the block, oldest first
  frame_res_t frame_results_q[$];

  function automatic void clear_frame_state();
    start_seen  = 1'b0;
    esc_pending = 1'b0;
    ovf_seen    = 1'b0;
    unesc_cnt   = '0;
    size_word   = '0;
    crc_word    = '0;
    crc_acc     = CrcAllOnes;
  endfunction

  // Reflected CRC-32, data bit folded in at the LSB each shift
  function automatic logic [31:0] crc32_fold_byte(input logic [31:0] crc_in,
                                                  input logic [7:0]  data);
    logic [31:0] r;
    r = crc_in;
    for (int i = 0; i < 8; i++) begin
      r = (r >> 1) ^ (CrcPoly & {32{r[0] ^ data[i]}});
    end
    return r;
  endfunction

  // One raw byte through the deframer; returns 1 when it causes a result
  function automatic bit deframe_byte(input logic [7:0] b, output frame_res_t res);
    logic [7:0] val;
    logic [8:0] plen;
    logic       hdr_ok;
    status_e    st;
    res = '0;
    if (b == EndByte) begin
      hdr_ok = (unesc_cnt >= HdrBytes);
      plen   = hdr_ok ? 9'(unesc_cnt - HdrBytes) : 9'd0;
      if (ovf_seen) begin
        st = ST_OVF;
      end else if (!hdr_ok || size_word != {23'd0, plen}) begin
        st = ST_SIZE;
      end else if ((crc_acc ^ CrcAllOnes) != crc_word) begin
        st = ST_CRC;
      end else begin
        st = ST_OK;
      end
      res.kind           = KindStatus;
      res.frame_status   = st;
      res.payload_length = plen;
      res.last           = 1'b1;
      clear_frame_state();
      return 1'b1;
    end
    // start byte value is don't-care
    if (!start_seen) begin
      start_seen = 1'b1;
      return 1'b0;
    end
    if (esc_pending) begin
      esc_pending = 1'b0;
      if (b == EscCodeFf) begin
        val = 8'hFF;
      end else if (b == EscCodeFe) begin
        val = 8'hFE;
      end else begin
        val = 8'h00;
      end
    end else if (b == EscByte) begin
      esc_pending = 1'b1;
      return 1'b0;
    end else begin
      val = b;
    end
    // header: size word then CRC word, little-endian
    if (unesc_cnt < 4) begin
      size_word = size_word | ({24'd0, val} << (8 * unesc_cnt));
      unesc_cnt++;
      return 1'b0;
    end
    if (unesc_cnt < HdrBytes) begin
      crc_word = crc_word | ({24'd0, val} << (8 * (unesc_cnt - 4)));
      unesc_cnt++;
      return 1'b0;
    end
    // past the payload limit: drop the byte, flag overflow
    if (unesc_cnt - HdrBytes >= MAX_PAYLOAD) begin
      ovf_seen = 1'b1;
      return 1'b0;
    end
    unesc_cnt++;
    crc_acc            = crc32_fold_byte(crc_acc, val);
    res.kind           = KindData;
    res.payload_byte   = val;
    return 1'b1;
  endfunction

  function automatic void note_fail(input string what, input frame_res_t want,
                                    input frame_res_t got);
    fail_count_o++;
    if (fail_count_o <= 10) begin
      $display("[%0t] %s: exp kind=%0d byte=%02h st=%0d len=%0d last=%0d",
               $time, what, want.kind, want.payload_byte, want.frame_status,
               want.payload_length, want.last);
      $display("[%0t] %s: got kind=%0d byte=%02h st=%0d len=%0d last=%0d",
               $time, what, got.kind, got.payload_byte, got.frame_status,
               got.payload_length, got.last);
    end
  endfunction

  // Compare results first, then log the byte accepted on the same edge
  always @(posedge clk_i or negedge rst_ni) begin : mon_blk
    frame_res_t got;
    frame_res_t want;
    frame_res_t nxt;
    if (!rst_ni) begin
      clear_frame_state();
      frame_results_q.delete();
      fail_count_o    = 0;
      pending_count_o = 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        got.kind           = res_mon.kind;
        got.payload_byte   = res_mon.payload_byte;
        got.frame_status   = status_e'(res_mon.frame_status);
        got.payload_length = res_mon.payload_length;
        got.last           = res_mon.last;
        if (frame_results_q.size() == 0) begin
          note_fail("unexpected result", '0, got);
        end else begin
          want = frame_results_q.pop_front();
          if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
              got.frame_status !== want.frame_status ||
              got.payload_length !== want.payload_length ||
              got.last !== want.last) begin
            note_fail("result mismatch", want, got);
          end
        end
      end
      if (rx_mon.valid && rx_mon.ready) begin
        if (deframe_byte(rx_mon.rx_byte, nxt)) begin
          frame_results_q.push_back(nxt);
        end
      end
      pending_count_o = frame_results_q.size();
    end
  end

endmodule

// ===== dv/tb_escaped_frame_receiver_crc32.sv =====
// ----------------------------------------------------------------------------
// tb_escaped_frame_receiver_crc32
// Drives byte-stuffed frames into the receiver: a few directed corner frames,
// then random frames, mostly well formed with random payloads, plus bad size,
// bad CRC, truncated headers, overflow and raw noise. Both handshake sides
// stall at random in two of three phases. The checker by the block predicts
// and compares; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_escaped_frame_receiver_crc32;
  import efr_pkg::*;

  localparam int unsigned NumBytes = 1450;

  typedef enum {
    FR_GOOD,
    FR_BAD_SIZE,
    FR_BAD_CRC,
    FR_SHORT,
    FR_NOISE
  } frame_flavor_e;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned fail_cnt;
  int unsigned pend_cnt;
  int unsigned tx_idle_pct  = 8;
  int unsigned rx_stall_pct = 51;
  int unsigned bytes_sent   = 0;
  int unsigned frame_no     = 0;
  logic [7:0]  body_q[$];

  efr_rx_if  rx_if ();
  efr_res_if res_if ();

  escaped_frame_receiver_crc32 u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  efr_frame_checker u_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rx_mon          (rx_if),
    .res_mon         (res_if),
    .fail_count_o    (fail_cnt),
    .pending_count_o (pend_cnt)
  );

  always #5 clk_i = ~clk_i;

  // Result side back-pressure
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      res_if.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Run limit
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  // Bias toward the framing and escape codes
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(4))
        0:       return 8'h00;
        1:       return EscCodeFe;
        2:       return EscCodeFf;
        3:       return EscByte;
        default: return EndByte;
      endcase
    end
    return 8'($urandom_range(255));
  endfunction

  // One raw byte, with random idle cycles ahead of it
  task automatic put_raw(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      rx_if.valid   <= 1'b0;
      rx_if.rx_byte <= 8'($urandom_range(255));
      @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    bytes_sent++;
  endtask

  // One unescaped value, stuffed as needed; zero sometimes via an odd code
  task automatic put_value(input logic [7:0] v);
    logic [7:0] code;
    if (v == EndByte) begin
      put_raw(EscByte);
      put_raw(EscCodeFf);
    end else if (v == EscByte) begin
      put_raw(EscByte);
      put_raw(EscCodeFe);
    end else if (v == 8'h00 && $urandom_range(2) == 0) begin
      do begin
        code = 8'($urandom_range(255));
      end while (code == EscCodeFe || code == EscCodeFf || code == EndByte);
      put_raw(EscByte);
      put_raw(code);
    end else begin
      put_raw(v);
    end
  endtask

  // CRC over body_q as the block would see it (only the first MAX bytes count)
  function automatic logic [31:0] body_crc();
    logic [31:0] crc;
    crc = CrcAllOnes;
    foreach (body_q[i]) begin
      if (i < MaxPayloadDflt) crc = crc_fold(crc, body_q[i]);
    end
    return crc ^ CrcAllOnes;
  endfunction

  task automatic emit_frame(input logic [31:0] size_w, input logic [31:0] crc_w);
    put_raw(8'($urandom_range(254)));
    for (int k = 0; k < 4; k++) put_value(size_w[8*k +: 8]);
    for (int k = 0; k < 4; k++) put_value(crc_w[8*k +: 8]);
    foreach (body_q[i]) put_value(body_q[i]);
    put_raw(EndByte);
  endtask

  task automatic send_frame(input frame_flavor_e flavor, input int unsigned len);
    logic [31:0] size_w;
    logic [31:0] crc_w;
    body_q.delete();
    case (flavor)
      FR_SHORT: begin
        // header cut short, sometimes with a dangling escape
        put_raw(8'($urandom_range(254)));
        repeat ($urandom_range(7)) put_value(pick_byte());
        if ($urandom_range(1) == 1) put_raw(EscByte);
        put_raw(EndByte);
      end
      FR_NOISE: begin
        repeat (len) put_raw(pick_byte());
        put_raw(EndByte);
      end
      default: begin
        repeat (len) body_q.push_back(pick_byte());
        size_w = len;
        crc_w  = body_crc();
        if (flavor == FR_BAD_SIZE) size_w ^= 32'd1 << $urandom_range(31);
        if (flavor == FR_BAD_CRC)  crc_w  ^= 32'd1 << $urandom_range(31);
        emit_frame(size_w, crc_w);
      end
    endcase
  endtask

  // Hold the sender until every owed result has come out
  task automatic wait_drained();
    rx_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pend_cnt != 0) @(posedge clk_i);
  endtask

  initial begin : stim_blk
    int unsigned sel;
    int unsigned len;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = 8'h00;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: end byte in place of the start byte
    put_raw(EndByte);
    // Short header closed right after an escape
    put_raw(8'h00);
    put_raw(8'h01);
    put_raw(EscByte);
    put_raw(EndByte);
    // Good frame whose payload needs every kind of stuffing
    body_q = '{8'hFF, 8'hFE, 8'h00};
    emit_frame(32'd3, body_crc());

    // Random frames over three idle phases
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct  = 8;
          rx_stall_pct = 51;
        end
        1: begin
          tx_idle_pct  = 51;
          rx_stall_pct = 8;
        end
        default: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
      endcase
      while (bytes_sent < (ph + 1) * NumBytes / 3) begin
        frame_no++;
        len = ($urandom_range(3) == 0) ? $urandom_range(40) : $urandom_range(12);
        sel = $urandom_range(99);
        if (frame_no == 6) begin
          send_frame(FR_GOOD, MaxPayloadDflt);
        end else if (frame_no == 14) begin
          send_frame(FR_GOOD, MaxPayloadDflt + 1 + $urandom_range(5));
        end else if (sel < 70) begin
          send_frame(FR_GOOD, len);
        end else if (sel < 78) begin
          send_frame(FR_BAD_SIZE, len);
        end else if (sel < 86) begin
          send_frame(FR_BAD_CRC, len);
        end else if (sel < 93) begin
          send_frame(FR_SHORT, len);
        end else begin
          send_frame(FR_NOISE, len);
        end
      end
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0 && pend_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/efr_pkg.sv
rtl/efr_rx_if.sv
rtl/efr_res_if.sv
rtl/efr_queue.sv
rtl/efr_front.sv
rtl/efr_back.sv
rtl/escaped_frame_receiver_crc32.sv
dv/efr_frame_checker.sv
dv/tb_escaped_frame_receiver_crc32.sv
